// ----- hw/rtl/pwsl_pkg.sv -----
// ----------------------------------------------------------------------------
// pwsl_pkg: shared types and constants for the PWM slew limiter
// Gear codes, configuration register indexes, field widths, reset values and bridge pin patterns.
// ----------------------------------------------------------------------------
package pwsl_pkg;

  // field widths
  localparam int unsigned GEAR_W  = 2;
  localparam int unsigned PEDAL_W = 12;
  localparam int unsigned THR_W   = 13;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // gear codes carried on the input channel
  typedef enum logic [GEAR_W-1:0] {
    GEAR_OFF  = 2'd0,
    GEAR_FWD  = 2'd1,
    GEAR_REV  = 2'd2,
    GEAR_KEEP = 2'd3
  } gear_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_THRESHOLD = 3'd0,
    CFG_FULL_SCALE   = 3'd1,
    CFG_MAX_DUTY     = 3'd2,
    CFG_STEP_UP      = 3'd3,
    CFG_STEP_DOWN    = 3'd4
  } cfg_idx_t;

  // configuration reset values
  localparam logic [THR_W-1:0]  RST_ON_THRESHOLD = 13'd2250;
  localparam logic [THR_W-1:0]  RST_FULL_SCALE   = 13'd3600;
  localparam logic [DUTY_W-1:0] RST_MAX_DUTY     = 16'd3599;
  localparam logic [DUTY_W-1:0] RST_STEP_UP      = 16'd80;
  localparam logic [DUTY_W-1:0] RST_STEP_DOWN    = 16'd160;

  // bridge pin patterns, bit 0 forward, bit 1 reverse
  localparam logic [1:0] PINS_OFF = 2'b00;
  localparam logic [1:0] PINS_FWD = 2'b01;
  localparam logic [1:0] PINS_REV = 2'b10;

endpackage

// ----- hw/rtl/pwm_slew_limiter_with_reverse_guard.sv -----
// Path: a request accepted into the input register reaches the out_ ports
//   through the head register, or through the skid register while out_stall holds the head.
// Throughput: one request per cycle while out_stall is low; the two-entry result buffer
//   takes one more request while one result waits under out_stall, then in_stall rises.
// Reset (rst_n low, synchronous): duty 0, forward direction, pins low,
//   configuration back to its default values, both channels empty.
// ----------------------------------------------------------------------------
// pwm_slew_limiter_with_reverse_guard
// Slews the PWM duty toward a pedal setpoint and ramps to zero before any
// change of bridge direction.
// ----------------------------------------------------------------------------
module pwm_slew_limiter_with_reverse_guard
  import pwsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [GEAR_W-1:0]    in_gear,
  input  logic [PEDAL_W-1:0]   in_pedal,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DUTY_W-1:0]    out_duty,
  output logic                 out_pin_forward,
  output logic                 out_pin_reverse,
  output logic                 out_reversal_ramp
);

  // one result as it travels through the output buffer
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [1:0]        pins;
    logic              ramp;
  } result_t;

  // configuration registers
  logic [THR_W-1:0]  on_thr_r;
  logic [THR_W-1:0]  full_scale_r;
  logic [DUTY_W-1:0] max_duty_r;
  logic [DUTY_W-1:0] step_up_r;
  logic [DUTY_W-1:0] step_dn_r;

  // input register
  logic               in_valid_r;
  gear_t              gear_r;
  logic [PEDAL_W-1:0] pedal_r;

  // control state; direction flags are 1 for reverse
  logic [DUTY_W-1:0] duty_r,    duty_nxt;
  logic              req_rev_r, req_rev_nxt;
  logic              app_rev_r, app_rev_nxt;
  logic [1:0]        pins_r,    pins_nxt;

  // output buffer: head drives the ports, skid catches one more
  logic    head_vld_r, skid_vld_r;
  result_t head_r, skid_r;
  result_t res;

  logic in_acc, advance, pop;
  logic [DUTY_W-1:0] setpoint;
  logic [DUTY_W-1:0] diff;
  logic [DUTY_W-1:0] slewed;
  logic              reversing;

  // handshakes
  assign in_acc   = in_valid && !in_stall;
  assign advance  = in_valid_r && !skid_vld_r;
  assign in_stall = in_valid_r && skid_vld_r;
  assign pop      = head_vld_r && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r     <= RST_ON_THRESHOLD;
      full_scale_r <= RST_FULL_SCALE;
      max_duty_r   <= RST_MAX_DUTY;
      step_up_r    <= RST_STEP_UP;
      step_dn_r    <= RST_STEP_DOWN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ON_THRESHOLD: on_thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_FULL_SCALE:   full_scale_r <= cfg_wdata[THR_W-1:0];
        CFG_MAX_DUTY:     max_duty_r   <= cfg_wdata;
        CFG_STEP_UP:      step_up_r    <= cfg_wdata;
        CFG_STEP_DOWN:    step_dn_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gear_r  <= gear_t'(in_gear);
      pedal_r <= in_pedal;
    end
  end

  // pedal to setpoint; the below-threshold test wins
  always_comb begin
    if ({1'b0, pedal_r} < on_thr_r) begin
      setpoint = '0;
    end else if ({1'b0, pedal_r} >= full_scale_r) begin
      setpoint = max_duty_r;
    end else begin
      setpoint = {{(DUTY_W-PEDAL_W){1'b0}}, pedal_r};
    end
  end

  // one control tick
  always_comb begin
    req_rev_nxt = req_rev_r;
    app_rev_nxt = app_rev_r;
    pins_nxt    = pins_r;
    duty_nxt    = duty_r;
    diff        = '0;
    slewed      = duty_r;
    reversing   = 1'b0;
    res.ramp    = 1'b0;

    case (gear_r)
      GEAR_FWD: req_rev_nxt = 1'b0;
      GEAR_REV: req_rev_nxt = 1'b1;
      default:  req_rev_nxt = req_rev_r;
    endcase

    if (gear_r == GEAR_OFF) begin
      // hard off, direction memory kept
      req_rev_nxt = req_rev_r;
      duty_nxt    = '0;
      pins_nxt    = PINS_OFF;
    end else begin
      reversing = (req_rev_nxt != app_rev_r) && (duty_r != '0);
      if (reversing) begin
        // ramp down with pins held
        duty_nxt = (duty_r > step_dn_r) ? (duty_r - step_dn_r) : '0;
        res.ramp = 1'b1;
      end else begin
        // apply the requested direction at zero duty
        if (duty_r == '0) begin
          app_rev_nxt = req_rev_nxt;
          pins_nxt    = req_rev_nxt ? PINS_REV : PINS_FWD;
        end
        // slew toward the setpoint, never past it
        if (setpoint > duty_r) begin
          diff   = setpoint - duty_r;
          slewed = duty_r + ((diff > step_up_r) ? step_up_r : diff);
        end else begin
          diff   = duty_r - setpoint;
          slewed = duty_r - ((diff > step_dn_r) ? step_dn_r : diff);
        end
        duty_nxt = (slewed > max_duty_r) ? max_duty_r : slewed;
      end
    end

    res.duty = duty_nxt;
    res.pins = pins_nxt;
  end

  // state update when the request leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r    <= '0;
      req_rev_r <= 1'b0;
      app_rev_r <= 1'b0;
      pins_r    <= PINS_OFF;
    end else if (advance) begin
      duty_r    <= duty_nxt;
      req_rev_r <= req_rev_nxt;
      app_rev_r <= app_rev_nxt;
      pins_r    <= pins_nxt;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!head_vld_r || pop) begin
        head_vld_r <= skid_vld_r || advance;
        skid_vld_r <= 1'b0;
      end else if (advance) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_vld_r || pop) begin
      head_r <= skid_vld_r ? skid_r : res;
    end else if (advance) begin
      skid_r <= res;
    end
  end

  // result ports
  assign out_valid         = head_vld_r;
  assign out_duty          = head_r.duty;
  assign out_pin_forward   = head_r.pins[0];
  assign out_pin_reverse   = head_r.pins[1];
  assign out_reversal_ramp = head_r.ramp;

endmodule

// ----- hw/rtl/pwsl_checker.sv -----
// ----------------------------------------------------------------------------
// pwsl_checker: port-level checks for the PWM slew limiter
// Watches the top level's ports only; attached by bind below.
// ----------------------------------------------------------------------------
module pwsl_checker
  import pwsl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_idx,
  input logic [CFG_DAT_W-1:0] cfg_wdata,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [GEAR_W-1:0]    in_gear,
  input logic [PEDAL_W-1:0]   in_pedal,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DUTY_W-1:0]    out_duty,
  input logic                 out_pin_forward,
  input logic                 out_pin_reverse,
  input logic                 out_reversal_ramp
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty)
      && $stable(out_pin_forward) && $stable(out_pin_reverse)
      && $stable(out_reversal_ramp))
    else $error("stalled result changed");

  // the bridge is never driven both ways
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pin_forward && out_pin_reverse))
    else $error("both bridge pins high");

  // nonzero duty always has a driven direction
  a_duty_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty != '0) |-> (out_pin_forward || out_pin_reverse))
    else $error("duty applied with bridge off");

  // a request needs at least one register stage before its result
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && !in_stall) && $past(rst_n) |=> 1'b1
      ##0 (!out_valid || $past(out_valid) || $past(in_valid, 2) || $past(in_valid)))
    else $error("result without a prior request");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channel not empty after reset");

endmodule

bind pwm_slew_limiter_with_reverse_guard pwsl_checker u_pwsl_checker (.*);
